/* hdl/assert_macros.svh */
// Assertion macros shared by the section parser modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is switched off while reset is high.
`define ASSERT_SYNC(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent check that also holds during reset.
`define ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hdl/psi_pkg.sv */
// Types and constants shared by the PSI section parser.
package psi_pkg;

   localparam int POS_W = 13;
   localparam int LEN_W = 12;
   localparam int CNT_W = 5;
   localparam int CSR_INDEX_W = 2;

   localparam logic [POS_W-1:0] POS_SAT         = 13'h1FFF;
   localparam logic [POS_W-1:0] POS_LENGTH      = 13'd2;
   localparam logic [POS_W-1:0] POS_ID          = 13'd4;
   localparam logic [POS_W-1:0] POS_VERSION     = 13'd5;
   localparam logic [POS_W-1:0] POS_PROG_INFO   = 13'd11;
   localparam logic [POS_W-1:0] PAT_FIRST_ENTRY = 13'd8;
   localparam logic [POS_W-1:0] PMT_LOOP_BASE   = 13'd12;

   localparam logic [7:0] TID_PAT = 8'h00;
   localparam logic [7:0] TID_PMT = 8'h02;

   // Kind of table being parsed.
   localparam logic [1:0] TK_IDLE = 2'd0;
   localparam logic [1:0] TK_PAT  = 2'd1;
   localparam logic [1:0] TK_PMT  = 2'd2;

   // Kind of result word.
   localparam logic [1:0] KIND_PAT     = 2'd0;
   localparam logic [1:0] KIND_PMT     = 2'd1;
   localparam logic [1:0] KIND_SUMMARY = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_PROGRAMS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_STREAMS  = 2'd1;

   localparam logic [CNT_W-1:0] RST_MAX_PROGRAMS = 5'd8;
   localparam logic [CNT_W-1:0] RST_MAX_STREAMS  = 5'd20;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       section_start;
   } req_type;

   typedef struct packed {
      logic [1:0]       entry_kind;
      logic [CNT_W-1:0] entry_index;
      logic [15:0]      number_or_type;
      logic [12:0]      packet_id;
      logic [LEN_W-1:0] info_length;
      logic [15:0]      stream_or_program_id;
      logic [4:0]       version;
      logic [LEN_W-1:0] section_len;
   } rsp_type;

   typedef struct packed {
      logic [CNT_W-1:0] max_programs;
      logic [CNT_W-1:0] max_streams;
   } cfg_type;

endpackage

/* hdl/psi_csr_regs.sv */
// Configuration registers of the PSI section parser.
module psi_csr_regs (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [psi_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [psi_pkg::CNT_W-1:0]          csr_wdata,
   output psi_pkg::cfg_type                   cfg
);
   import psi_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MAX_PROGRAMS: cfg_in.max_programs = csr_wdata;
            CSR_MAX_STREAMS:  cfg_in.max_streams  = csr_wdata;
            default: begin
               // Writes to unused indexes are dropped.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_programs <= RST_MAX_PROGRAMS;
         cfg_ff.max_streams  <= RST_MAX_STREAMS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* hdl/psi_parse_core.sv */
// Per-byte section state and result formation for the PSI section parser.
`include "assert_macros.svh"

module psi_parse_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  psi_pkg::req_type req_word,
   input  psi_pkg::cfg_type cfg,
   output logic             res_hit,
   output psi_pkg::rsp_type res_word
);
   import psi_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] nes_ff, nes_in;
   logic [1:0]       tk_ff, tk_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] pinfo_ff, pinfo_in;
   logic [39:0]      bytes_ff, bytes_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [15:0]      id_ff, id_in;
   logic [4:0]       ver_ff, ver_in;

   logic [39:0]      shifted;
   logic [LEN_W-1:0] len_cur, pinfo_cur, es_len;
   logic [POS_W-1:0] nes_cur;
   logic [15:0]      id_cur;
   logic [4:0]       ver_cur;
   logic [CNT_W-1:0] count_cur;
   logic [POS_W:0]   pos_x, nes_x, len_x, pat_next, pmt_next;
   logic             prog_info_byte, pat_match, pmt_match, under_cap, entry_hit, summary;

   always_comb begin
      shifted        = {bytes_ff[31:0], req_word.data_byte};
      es_len         = shifted[LEN_W-1:0];
      prog_info_byte = (pos_ff == POS_PROG_INFO) && (tk_ff == TK_PMT);
      len_cur   = (pos_ff == POS_LENGTH) ? shifted[LEN_W-1:0] : len_ff;
      pinfo_cur = prog_info_byte ? shifted[LEN_W-1:0] : pinfo_ff;
      // The stream loop begins right after the program descriptors.
      nes_cur   = prog_info_byte ? (PMT_LOOP_BASE + {1'b0, shifted[LEN_W-1:0]}) : nes_ff;
      id_cur    = (pos_ff == POS_ID) ? shifted[15:0] : id_ff;
      ver_cur   = (pos_ff == POS_VERSION) ? req_word.data_byte[5:1] : ver_ff;

      pos_x = {1'b0, pos_ff};
      nes_x = {1'b0, nes_cur};
      len_x = {2'b00, len_cur};

      // An entry counts only if its last byte lies before the four CRC bytes.
      pat_match = (tk_ff == TK_PAT) && (pos_x == nes_x + 14'd3) && (nes_x + 14'd5 <= len_x);
      pmt_match = (tk_ff == TK_PMT) && (pos_x == nes_x + 14'd4) && (nes_x + 14'd6 <= len_x);
      under_cap = pat_match ? (count_ff < cfg.max_programs) : (count_ff < cfg.max_streams);
      entry_hit = (pat_match || pmt_match) && under_cap;
      count_cur = count_ff + {{(CNT_W-1){1'b0}}, entry_hit};

      pat_next = nes_x + 14'd4;
      pmt_next = nes_x + 14'd5 + {2'b00, es_len};

      summary = (pos_ff >= POS_LENGTH) && (pos_x == len_x + 14'd2);
   end

   always_comb begin
      pos_in   = pos_ff;
      nes_in   = nes_ff;
      tk_in    = tk_ff;
      len_in   = len_ff;
      pinfo_in = pinfo_ff;
      bytes_in = bytes_ff;
      count_in = count_ff;
      id_in    = id_ff;
      ver_in   = ver_ff;
      res_hit  = 1'b0;
      res_word = '0;

      if (req_word.section_start) begin
         if (req_word.data_byte == TID_PAT) begin
            tk_in = TK_PAT;
         end else if (req_word.data_byte == TID_PMT) begin
            tk_in = TK_PMT;
         end else begin
            tk_in = TK_IDLE;
         end
         pos_in   = {{(POS_W-1){1'b0}}, 1'b1};
         len_in   = '0;
         pinfo_in = '0;
         nes_in   = (tk_in == TK_PAT) ? PAT_FIRST_ENTRY : POS_SAT;
         bytes_in = {32'd0, req_word.data_byte};
         count_in = '0;
         id_in    = '0;
         ver_in   = '0;
      end else if (tk_ff != TK_IDLE) begin
         bytes_in = shifted;
         len_in   = len_cur;
         pinfo_in = pinfo_cur;
         id_in    = id_cur;
         ver_in   = ver_cur;
         count_in = count_cur;
         nes_in   = nes_cur;
         if (pat_match) begin
            nes_in = (pat_next > {1'b0, POS_SAT}) ? POS_SAT : pat_next[POS_W-1:0];
         end else if (pmt_match) begin
            nes_in = (pmt_next > {1'b0, POS_SAT}) ? POS_SAT : pmt_next[POS_W-1:0];
         end

         if (entry_hit) begin
            res_hit              = 1'b1;
            res_word.entry_index = count_ff;
            if (pat_match) begin
               res_word.entry_kind     = KIND_PAT;
               res_word.number_or_type = shifted[31:16];
               res_word.packet_id      = shifted[12:0];
            end else begin
               res_word.entry_kind     = KIND_PMT;
               res_word.number_or_type = {8'd0, shifted[39:32]};
               res_word.packet_id      = shifted[28:16];
               res_word.info_length    = es_len;
            end
         end

         if (summary) begin
            // The summary replaces an entry that ends on the same byte.
            res_hit                       = 1'b1;
            res_word                      = '0;
            res_word.entry_kind           = KIND_SUMMARY;
            res_word.entry_index          = count_cur;
            res_word.info_length          = (tk_ff == TK_PMT) ? pinfo_cur : '0;
            res_word.stream_or_program_id = id_cur;
            res_word.version              = ver_cur;
            res_word.section_len          = len_cur;
            tk_in  = TK_IDLE;
            pos_in = '0;
         end else begin
            pos_in = (pos_ff == POS_SAT) ? POS_SAT : pos_ff + 13'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         nes_ff   <= '0;
         tk_ff    <= TK_IDLE;
         len_ff   <= '0;
         pinfo_ff <= '0;
         bytes_ff <= '0;
         count_ff <= '0;
         id_ff    <= '0;
         ver_ff   <= '0;
      end else if (step) begin
         pos_ff   <= pos_in;
         nes_ff   <= nes_in;
         tk_ff    <= tk_in;
         len_ff   <= len_in;
         pinfo_ff <= pinfo_in;
         bytes_ff <= bytes_in;
         count_ff <= count_in;
         id_ff    <= id_in;
         ver_ff   <= ver_in;
      end
   end

   `ASSERT_SYNC(a_active_pos_nonzero, clock, reset, (tk_ff != TK_IDLE) |-> (pos_ff != '0), "active section with zero byte position")
   `ASSERT_SYNC(a_summary_goes_idle, clock, reset, (step && res_hit && (res_word.entry_kind == KIND_SUMMARY)) |=> (tk_ff == TK_IDLE), "parser not idle after summary")
   `ASSERT_SYNC(a_pat_under_cap, clock, reset, (step && res_hit && (res_word.entry_kind == KIND_PAT)) |-> (res_word.entry_index < cfg.max_programs), "program entry beyond cap")

endmodule

/* hdl/psi_section_parser.sv */
// Top level of the PSI section parser: input register, parse core, result register.
//
// The block takes one section byte per cycle while rsp_stall is low and gives at most one
// result word per byte: a byte passes from the input register through the parse core
// into the result register, from which its result word is presented on rsp_data, and a
// new byte is accepted in every cycle while rsp_stall is low. The rate is set by the
// parse core, which updates its per-section state for each byte; while the result
// register holds a word and rsp_stall is high, the byte waits in the input register and
// req_stall rises in the same cycle.
`include "assert_macros.svh"

module psi_section_parser (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  psi_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output psi_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [psi_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [psi_pkg::CNT_W-1:0]       csr_wdata
);
   import psi_pkg::*;

   cfg_type cfg;
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   logic    step, accept, res_hit;
   rsp_type res_word;

   psi_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   psi_parse_core u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .req_word (in_data_ff),
      .cfg      (cfg),
      .res_hit  (res_hit),
      .res_word (res_word)
   );

   // The held byte is processed once the result register is free or being emptied.
   assign step      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !step;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (step && res_hit) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (step && res_hit) begin
         out_data_ff <= res_word;
      end
   end

   `ASSERT_SYNC(a_stall_needs_word, clock, reset, req_stall |-> in_valid_ff, "input stalled with empty input register")
   `ASSERT_SYNC(a_result_lands, clock, reset, (step && res_hit) |=> rsp_valid, "result word lost on its way to the output")
   `ASSERT_SYNC(a_step_has_room, clock, reset, (step && out_valid_ff) |-> !rsp_stall, "byte processed while result register is blocked")

endmodule
